FILE: rtl/pca_pkg.sv
// Shared constants, word widths and control/status types of the point covariance accumulator.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package pca_pkg;

  // Default parameter values
  localparam int unsigned MAX_POINTS = 32768;
  localparam int unsigned COORD_BITS = 24;

  // Word widths (fixed by the point and result formats)
  localparam int unsigned CoordW   = 24;          // Q12.12 coordinate
  localparam int unsigned SumW     = 39;          // Q27.12 first-moment sum
  localparam int unsigned MomW     = 63;          // Q39.24 second-moment sum
  localparam int unsigned CntW     = 16;          // point count, holds MAX_POINTS
  localparam int unsigned MagW     = SumW;        // magnitude of a first-moment sum
  localparam int unsigned ProdW    = 2 * MagW;    // exact product of two magnitudes
  localparam int unsigned ResW     = 64;          // Q40.24 scatter entry
  localparam int unsigned MulSteps = MagW;        // one multiplier bit per step
  localparam int unsigned DivSteps = ProdW;       // one dividend bit per step
  localparam int unsigned StepW    = $clog2(DivSteps);

  // Scatter matrix entries, in output order
  localparam int unsigned NumEntries = 6;
  localparam int unsigned EntW       = $clog2(NumEntries);

  localparam logic [EntW-1:0] EntXX = EntW'(0);
  localparam logic [EntW-1:0] EntYY = EntW'(1);
  localparam logic [EntW-1:0] EntZZ = EntW'(2);
  localparam logic [EntW-1:0] EntXY = EntW'(3);
  localparam logic [EntW-1:0] EntXZ = EntW'(4);
  localparam logic [EntW-1:0] EntYZ = EntW'(5);

  // Commands from the controller to the datapath
  typedef struct packed {
    logic            load;      // latch operand magnitudes, clear product
    logic            mul_step;  // one shift-add multiply step
    logic            div_step;  // one restoring divide step
    logic            store;     // write finished entry to the result bank
    logic            clear;     // clear sums, count and overflow flag
    logic [EntW-1:0] entry;     // entry being finished
  } pca_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic pipe_busy;            // a point is still in the accumulate pipeline
  } pca_status_t;

endpackage

FILE: rtl/pca_ctrl.sv
// Controller of the point covariance accumulator: sequences the drain, the serial
// multiply/divide finish of the six entries and the result strobe. Depends on pca_pkg.
`timescale 1ns / 1ps

module pca_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic                 last_point_i,
  input  pca_pkg::pca_status_t status_i,
  output pca_pkg::pca_cmd_t    cmd_o,
  output logic                 busy_o,
  output logic                 valid_o
);
  import pca_pkg::*;

  localparam logic [2:0] StRun   = 3'd0;
  localparam logic [2:0] StDrain = 3'd1;
  localparam logic [2:0] StLoad  = 3'd2;
  localparam logic [2:0] StMul   = 3'd3;
  localparam logic [2:0] StDiv   = 3'd4;
  localparam logic [2:0] StStore = 3'd5;
  localparam logic [2:0] StOut   = 3'd6;

  localparam logic [StepW-1:0] MulLast = StepW'(MulSteps - 1);
  localparam logic [StepW-1:0] DivLast = StepW'(DivSteps - 1);
  localparam logic [EntW-1:0]  EntLast = EntW'(NumEntries - 1);

  logic [2:0]       state_q, state_d;
  logic [StepW-1:0] step_q, step_d;
  logic [EntW-1:0]  entry_q, entry_d;

  // Next state and counters
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    entry_d = entry_q;
    unique case (state_q)
      StRun: begin
        if (start_i && last_point_i) begin
          state_d = StDrain;
        end
      end
      StDrain: begin
        if (!status_i.pipe_busy) begin
          state_d = StLoad;
          entry_d = EntXX;
        end
      end
      StLoad: begin
        state_d = StMul;
        step_d  = '0;
      end
      StMul: begin
        if (step_q == MulLast) begin
          state_d = StDiv;
          step_d  = '0;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      StDiv: begin
        if (step_q == DivLast) begin
          state_d = StStore;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      StStore: begin
        if (entry_q == EntLast) begin
          state_d = StOut;
        end else begin
          entry_d = entry_q + 1'b1;
          state_d = StLoad;
        end
      end
      StOut: begin
        state_d = StRun;
      end
      default: begin
        state_d = StRun;
      end
    endcase
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StRun;
      step_q  <= '0;
      entry_q <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      entry_q <= entry_d;
    end
  end

  // Command decode
  always_comb begin
    cmd_o          = '0;
    cmd_o.entry    = entry_q;
    cmd_o.load     = (state_q == StLoad);
    cmd_o.mul_step = (state_q == StMul);
    cmd_o.div_step = (state_q == StDiv);
    cmd_o.store    = (state_q == StStore);
    cmd_o.clear    = (state_q == StOut);
  end

  assign busy_o  = (state_q != StRun);
  assign valid_o = (state_q == StOut);

  // At most one datapath operation per cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.load, cmd_o.mul_step, cmd_o.div_step, cmd_o.store, cmd_o.clear}))
    else $error("pca_ctrl: more than one datapath command");

  // The result word only follows the store of the last entry
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> ($past(state_q) == StStore) && ($past(entry_q) == EntLast))
    else $error("pca_ctrl: result strobe without finished entries");

  // The divide phase always starts from a cleared step counter
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDiv) && ($past(state_q) == StMul) |-> (step_q == '0))
    else $error("pca_ctrl: divide phase started mid-count");

endmodule

FILE: rtl/pca_dp.sv
// Datapath of the point covariance accumulator: product pipeline, moment sums, point count,
// serial multiply/divide unit and result bank. Depends on pca_pkg.
`timescale 1ns / 1ps

module pca_dp #(
  parameter int unsigned MaxPoints = pca_pkg::MAX_POINTS,
  parameter int unsigned CoordBits = pca_pkg::COORD_BITS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              accept_i,
  input  logic [pca_pkg::CoordW-1:0]        point_x_i,
  input  logic [pca_pkg::CoordW-1:0]        point_y_i,
  input  logic [pca_pkg::CoordW-1:0]        point_z_i,
  input  pca_pkg::pca_cmd_t                 cmd_i,
  output pca_pkg::pca_status_t              status_o,
  output logic signed [pca_pkg::ResW-1:0]   cov_xx_o,
  output logic signed [pca_pkg::ResW-1:0]   cov_yy_o,
  output logic signed [pca_pkg::ResW-1:0]   cov_zz_o,
  output logic signed [pca_pkg::ResW-1:0]   cov_xy_o,
  output logic signed [pca_pkg::ResW-1:0]   cov_xz_o,
  output logic signed [pca_pkg::ResW-1:0]   cov_yz_o,
  output logic                              overflow_o
);
  import pca_pkg::*;

  localparam logic [CntW-1:0] MaxCnt = CntW'(MaxPoints);
  localparam int unsigned     PW     = 2 * CoordW;

  // Coordinates sign-extended from the used width
  logic signed [CoordW-1:0] x_in, y_in, z_in;
  assign x_in = CoordW'(signed'(point_x_i[CoordBits-1:0]));
  assign y_in = CoordW'(signed'(point_y_i[CoordBits-1:0]));
  assign z_in = CoordW'(signed'(point_z_i[CoordBits-1:0]));

  // Stage 1: registered point
  logic                     s1_vld_q;
  logic signed [CoordW-1:0] x1_q, y1_q, z1_q;
  // Stage 2: registered products
  logic                     s2_vld_q;
  logic signed [CoordW-1:0] x2_q, y2_q, z2_q;
  logic signed [PW-1:0]     pxx_q, pyy_q, pzz_q, pxy_q, pxz_q, pyz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= accept_i;
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      x1_q <= x_in;
      y1_q <= y_in;
      z1_q <= z_in;
    end
    if (s1_vld_q) begin
      x2_q  <= x1_q;
      y2_q  <= y1_q;
      z2_q  <= z1_q;
      pxx_q <= x1_q * x1_q;
      pyy_q <= y1_q * y1_q;
      pzz_q <= z1_q * z1_q;
      pxy_q <= x1_q * y1_q;
      pxz_q <= x1_q * z1_q;
      pyz_q <= y1_q * z1_q;
    end
  end

  assign status_o.pipe_busy = s1_vld_q | s2_vld_q;

  // Stage 3: moment sums, count saturates at the point limit
  logic signed [SumW-1:0] sx_q, sy_q, sz_q;
  logic signed [MomW-1:0] sxx_q, syy_q, szz_q, sxy_q, sxz_q, syz_q;
  logic [CntW-1:0]        cnt_q;
  logic                   ovf_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sx_q  <= '0;
      sy_q  <= '0;
      sz_q  <= '0;
      sxx_q <= '0;
      syy_q <= '0;
      szz_q <= '0;
      sxy_q <= '0;
      sxz_q <= '0;
      syz_q <= '0;
      cnt_q <= '0;
      ovf_q <= 1'b0;
    end else if (cmd_i.clear) begin
      sx_q  <= '0;
      sy_q  <= '0;
      sz_q  <= '0;
      sxx_q <= '0;
      syy_q <= '0;
      szz_q <= '0;
      sxy_q <= '0;
      sxz_q <= '0;
      syz_q <= '0;
      cnt_q <= '0;
      ovf_q <= 1'b0;
    end else if (s2_vld_q) begin
      if (cnt_q == MaxCnt) begin
        ovf_q <= 1'b1;
      end else begin
        sx_q  <= sx_q + SumW'(x2_q);
        sy_q  <= sy_q + SumW'(y2_q);
        sz_q  <= sz_q + SumW'(z2_q);
        sxx_q <= sxx_q + MomW'(pxx_q);
        syy_q <= syy_q + MomW'(pyy_q);
        szz_q <= szz_q + MomW'(pzz_q);
        sxy_q <= sxy_q + MomW'(pxy_q);
        sxz_q <= sxz_q + MomW'(pxz_q);
        syz_q <= syz_q + MomW'(pyz_q);
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  // Operand select for the entry being finished
  logic signed [SumW-1:0] a_sel, b_sel;
  logic signed [MomW-1:0] s2_sel;

  always_comb begin
    unique case (cmd_i.entry)
      EntXX: begin a_sel = sx_q; b_sel = sx_q; s2_sel = sxx_q; end
      EntYY: begin a_sel = sy_q; b_sel = sy_q; s2_sel = syy_q; end
      EntZZ: begin a_sel = sz_q; b_sel = sz_q; s2_sel = szz_q; end
      EntXY: begin a_sel = sx_q; b_sel = sy_q; s2_sel = sxy_q; end
      EntXZ: begin a_sel = sx_q; b_sel = sz_q; s2_sel = sxz_q; end
      EntYZ: begin a_sel = sy_q; b_sel = sz_q; s2_sel = syz_q; end
      default: begin a_sel = '0; b_sel = '0; s2_sel = '0; end
    endcase
  end

  logic [MagW-1:0] ma_c, mb_c;
  assign ma_c = a_sel[SumW-1] ? MagW'(-a_sel) : MagW'(a_sel);
  assign mb_c = b_sel[SumW-1] ? MagW'(-b_sel) : MagW'(b_sel);

  // Serial unit: MSB-first shift-add multiply, then restoring divide in the same
  // shift register (dividend bits leave at the top, quotient bits enter at the bottom)
  logic [MagW-1:0]  ma_q, mb_q;
  logic [ProdW-1:0] acc_q;
  logic [CntW-1:0]  rem_q;
  logic             neg_q;

  logic [CntW:0]    trial;
  logic             q_bit;
  logic [CntW-1:0]  rem_d;

  always_comb begin
    trial = {rem_q, acc_q[ProdW-1]};
    q_bit = (trial >= {1'b0, cnt_q});
    rem_d = q_bit ? CntW'(trial - {1'b0, cnt_q}) : trial[CntW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      ma_q  <= ma_c;
      mb_q  <= mb_c;
      neg_q <= a_sel[SumW-1] ^ b_sel[SumW-1];
      acc_q <= '0;
      rem_q <= '0;
    end else if (cmd_i.mul_step) begin
      acc_q <= (acc_q << 1) + (mb_q[MagW-1] ? ProdW'(ma_q) : '0);
      mb_q  <= mb_q << 1;
    end else if (cmd_i.div_step) begin
      acc_q <= {acc_q[ProdW-2:0], q_bit};
      rem_q <= rem_d;
    end
  end

  // Entry = S2 - sign * (|a*b| / count), quotient kept modulo 2^64
  logic [ResW-1:0] quo, s2_ext, entry_val;
  assign quo       = (cnt_q == '0) ? '0 : acc_q[ResW-1:0];
  assign s2_ext    = ResW'(s2_sel);
  assign entry_val = neg_q ? (s2_ext + quo) : (s2_ext - quo);

  // Result bank
  logic [ResW-1:0] res_q [NumEntries];

  always_ff @(posedge clk_i) begin
    if (cmd_i.store) begin
      res_q[cmd_i.entry] <= entry_val;
    end
  end

  assign cov_xx_o   = res_q[EntXX];
  assign cov_yy_o   = res_q[EntYY];
  assign cov_zz_o   = res_q[EntZZ];
  assign cov_xy_o   = res_q[EntXY];
  assign cov_xz_o   = res_q[EntXZ];
  assign cov_yz_o   = res_q[EntYZ];
  assign overflow_o = ovf_q;

  // Count never passes the point limit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= MaxCnt)
    else $error("pca_dp: point count above limit");

  // Overflow is only flagged once the count has saturated
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ovf_q) |-> (cnt_q == MaxCnt))
    else $error("pca_dp: overflow flagged below the limit");

  // Sums are only cleared with an empty pipeline
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.clear |-> !(s1_vld_q || s2_vld_q))
    else $error("pca_dp: clear while points are in flight");

endmodule

FILE: rtl/point_covariance_accumulator.sv
// Point covariance accumulator: one point word per cycle while busy_o is low, into a pipe of
// registered point, products and moment sums. A point marked last raises busy_o for its drain,
// then per entry a 39-step shift-add multiply and a 78-step restoring divide in one shared
// serial unit. The result word shows for one cycle on valid_o at the end; the receiver cannot
// stall it. Reset (asynchronous, active low) clears the sums, the count and the overflow flag.
// Top level; depends on pca_pkg, pca_ctrl and pca_dp.
`timescale 1ns / 1ps

module point_covariance_accumulator #(
  parameter int unsigned MaxPoints = pca_pkg::MAX_POINTS,
  parameter int unsigned CoordBits = pca_pkg::COORD_BITS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic signed [pca_pkg::CoordW-1:0] point_x_i,
  input  logic signed [pca_pkg::CoordW-1:0] point_y_i,
  input  logic signed [pca_pkg::CoordW-1:0] point_z_i,
  input  logic                              last_point_i,
  output logic                              valid_o,
  output logic signed [pca_pkg::ResW-1:0]   cov_xx_o,
  output logic signed [pca_pkg::ResW-1:0]   cov_yy_o,
  output logic signed [pca_pkg::ResW-1:0]   cov_zz_o,
  output logic signed [pca_pkg::ResW-1:0]   cov_xy_o,
  output logic signed [pca_pkg::ResW-1:0]   cov_xz_o,
  output logic signed [pca_pkg::ResW-1:0]   cov_yz_o,
  output logic                              overflow_o
);
  import pca_pkg::*;

  pca_cmd_t    cmd;
  pca_status_t status;
  logic        accept;

  // A point word is taken whenever start_i is high and the controller is not finishing a set
  assign accept = start_i && !busy_o;

  pca_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (accept),
    .last_point_i (last_point_i),
    .status_i     (status),
    .cmd_o        (cmd),
    .busy_o       (busy_o),
    .valid_o      (valid_o)
  );

  pca_dp #(
    .MaxPoints (MaxPoints),
    .CoordBits (CoordBits)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .point_x_i  (point_x_i),
    .point_y_i  (point_y_i),
    .point_z_i  (point_z_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .cov_xx_o   (cov_xx_o),
    .cov_yy_o   (cov_yy_o),
    .cov_zz_o   (cov_zz_o),
    .cov_xy_o   (cov_xy_o),
    .cov_xz_o   (cov_xz_o),
    .cov_yz_o   (cov_yz_o),
    .overflow_o (overflow_o)
  );

endmodule
